FILE: hdl/cpc_pkg.sv
package cpc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int DATA_WIDTH_DEF    = 16;
  localparam int ATAN_ENTRIES      = 24;

  // fixed-point layout
  localparam int GUARD = 14;  // guard bits on Cartesian inputs
  localparam int ZW    = 26;  // angle accumulator, degrees * 2^16

  localparam logic signed [16:0] KGAIN = 17'sd39797;  // 1/CORDIC gain, Q0.16

  localparam logic signed [15:0] DEG90_Q6  = 16'sd5760;
  localparam logic signed [15:0] DEG180_Q6 = 16'sd11520;
  localparam logic signed [15:0] DEG360_Q6 = 16'sd23040;

  // 360 deg in Q6 = 45 * 2^9; 2^12 == 1 (mod 45), 2^23 == 23 (mod 45)
  localparam int           DEG360_ODD   = 45;
  localparam logic [12:0]  SIGN_FOLD    = 13'd22;     // -2^23 mod 45
  localparam logic [14:0]  RECIP45      = 15'd23302;  // ceil(2^20 / 45)

  localparam logic [0:0] MODE_C2P = 1'b0;
  localparam logic [0:0] MODE_P2C = 1'b1;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_POLE = 2'd1;
  localparam logic [1:0] STAT_NEG  = 2'd2;

  // atan(2^-i) in degrees * 2^16
  localparam int ATAN_DEG16 [0:ATAN_ENTRIES-1] = '{
    2949120, 1740967, 919879, 475137, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic       valid;
    logic       mode;
    logic       flip;
    logic [1:0] status;
  } cpc_ctl_t;

endpackage

FILE: hdl/cartesian_polar_converter_top.sv
// Cartesian <-> polar converter, fully unrolled CORDIC pipeline.
// Pipeline from input transfer to out_tvalid:
//   one prepare stage, one angle-reduction stage, one stage per CORDIC iteration,
//   one gain-multiply stage and the output register.
// Throughput: one point per cycle; the whole pipeline holds while out_tvalid waits.
// Reset: synchronous, active-low rst_n clears all valid bits; data registers are not reset.
module cartesian_polar_converter_top #(
  parameter int CORDIC_STAGES = cpc_pkg::CORDIC_STAGES_DEF,
  parameter int DATA_WIDTH    = cpc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_tvalid,
  output logic                                        in_tready,
  // coord_a, coord_b
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]           in_tdata,
  // mode
  input  logic                                        in_tuser,
  output logic                                        out_tvalid,
  input  logic                                        out_tready,
  // result_a, result_b
  output logic [((2*DATA_WIDTH+2+7)/8)*8-1:0]         out_tdata,
  // status
  output logic [1:0]                                  out_tuser
);

  localparam int IW      = DATA_WIDTH + 18;
  localparam int ZW      = cpc_pkg::ZW;
  localparam int OW      = DATA_WIDTH + 1;
  localparam int PW      = IW + 17;
  localparam int MW      = DATA_WIDTH + 17;
  localparam int OUT_TDW = ((2*DATA_WIDTH+2+7)/8)*8;
  localparam int N       = CORDIC_STAGES;

  localparam logic signed [IW-1:0] Y_ZERO   = '0;
  localparam logic signed [ZW-1:0] Z180     = ZW'(cpc_pkg::DEG180_Q6) <<< 10;
  localparam logic signed [ZW-1:0] Z_RND    = ZW'(512);
  localparam logic signed [ZW-1:0] ZCLAMP   = ZW'(cpc_pkg::DEG180_Q6);
  localparam logic signed [PW-1:0] MAXV_P   = (PW'(1) <<< DATA_WIDTH) - PW'(1);
  localparam logic signed [PW-1:0] RND_C2P  = PW'(1) <<< (cpc_pkg::GUARD + 15);
  localparam logic signed [PW-1:0] RND_P2C  = PW'(32768);

  logic adv;
  logic out_tvalid_r;
  assign adv       = !out_tvalid_r || out_tready;
  assign in_tready = adv;

  // ---------------- stage 1: prepare ----------------
  logic signed [DATA_WIDTH-1:0] in_a, in_b;
  logic signed [MW-1:0]         a_gain;
  logic signed [IW-1:0]         a_ext, b_ext;
  logic signed [32:0]           b33;
  logic [23:0]                  bq;
  cpc_pkg::cpc_ctl_t            s1_ctl_nxt, s1_ctl_r;
  logic signed [IW-1:0]         s1_x_nxt, s1_x_r, s1_y_nxt, s1_y_r;
  logic signed [ZW-1:0]         s1_z_nxt, s1_z_r;
  logic [12:0]                  s1_v_nxt, s1_v_r;
  logic [8:0]                   s1_blo_nxt, s1_blo_r;

  assign in_a = signed'(in_tdata[DATA_WIDTH-1:0]);
  assign in_b = signed'(in_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);

  always_comb begin
    a_gain = MW'(in_a) * MW'(cpc_pkg::KGAIN);
    a_ext  = IW'(in_a) <<< cpc_pkg::GUARD;
    b_ext  = IW'(in_b) <<< cpc_pkg::GUARD;
    b33    = 33'(in_b);
    bq     = b33[32:9];
    // floor(b / 512) mod 45, folded into a small sum
    s1_v_nxt   = 13'(bq[11:0]) + 13'(bq[22:12]) + (bq[23] ? cpc_pkg::SIGN_FOLD : 13'd0);
    s1_blo_nxt = b33[8:0];

    s1_ctl_nxt.valid  = in_tvalid;
    s1_ctl_nxt.mode   = in_tuser;
    s1_ctl_nxt.flip   = 1'b0;
    s1_ctl_nxt.status = cpc_pkg::STAT_OK;
    s1_z_nxt          = '0;
    if (in_tuser == cpc_pkg::MODE_P2C) begin
      s1_x_nxt = IW'(a_gain);
      s1_y_nxt = Y_ZERO;
      if (in_a == '0) begin
        s1_ctl_nxt.status = cpc_pkg::STAT_POLE;
      end else if (in_a < 0) begin
        s1_ctl_nxt.status = cpc_pkg::STAT_NEG;
      end
    end else begin
      if (in_a < 0) begin
        // turn the vector by 180 degrees into the right half plane
        s1_x_nxt = -a_ext;
        s1_y_nxt = -b_ext;
        s1_z_nxt = (in_b >= 0) ? Z180 : -Z180;
      end else begin
        s1_x_nxt = a_ext;
        s1_y_nxt = b_ext;
      end
      if (in_a == '0 && in_b == '0) begin
        s1_ctl_nxt.status = cpc_pkg::STAT_POLE;
      end
    end
  end

  // ---------------- stage 2: angle reduction, CORDIC entry ----------------
  cpc_pkg::cpc_ctl_t    c_ctl_nxt [0:N];
  cpc_pkg::cpc_ctl_t    c_ctl_r   [0:N];
  logic signed [IW-1:0] c_x_nxt   [0:N];
  logic signed [IW-1:0] c_x_r     [0:N];
  logic signed [IW-1:0] c_y_nxt   [0:N];
  logic signed [IW-1:0] c_y_r     [0:N];
  logic signed [ZW-1:0] c_z_nxt   [0:N];
  logic signed [ZW-1:0] c_z_r     [0:N];

  logic [27:0]          qq_prod;
  logic [12:0]          rem13;
  logic [14:0]          m360;
  logic signed [15:0]   ang0, ang1;
  logic                 flip;

  always_comb begin
    qq_prod = 28'(s1_v_r) * 28'(cpc_pkg::RECIP45);
    rem13   = s1_v_r - 13'(qq_prod[27:20]) * 13'(cpc_pkg::DEG360_ODD);
    m360    = {rem13[5:0], s1_blo_r};
    ang0    = signed'(16'(m360));
    if (ang0 >= cpc_pkg::DEG180_Q6) begin
      ang0 = ang0 - cpc_pkg::DEG360_Q6;
    end
    flip = 1'b0;
    ang1 = ang0;
    // fold into [-90, 90]; the result is negated at the end
    if (ang0 > cpc_pkg::DEG90_Q6) begin
      ang1 = ang0 - cpc_pkg::DEG180_Q6;
      flip = 1'b1;
    end else if (ang0 < -cpc_pkg::DEG90_Q6) begin
      ang1 = ang0 + cpc_pkg::DEG180_Q6;
      flip = 1'b1;
    end

    c_ctl_nxt[0]      = s1_ctl_r;
    c_x_nxt[0]        = s1_x_r;
    c_y_nxt[0]        = s1_y_r;
    if (s1_ctl_r.mode == cpc_pkg::MODE_P2C) begin
      c_ctl_nxt[0].flip = flip;
      c_z_nxt[0]        = ZW'(ang1) <<< 10;
    end else begin
      c_z_nxt[0]        = s1_z_r;
    end
  end

  // ---------------- CORDIC iterations, one per stage ----------------
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [IW-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    logic                 ccw;

    always_comb begin
      xs  = c_x_r[i] >>> i;
      ys  = c_y_r[i] >>> i;
      at  = ZW'(cpc_pkg::ATAN_DEG16[i]);
      ccw = (c_ctl_r[i].mode == cpc_pkg::MODE_C2P) ? c_y_r[i][IW-1] : !c_z_r[i][ZW-1];
      c_ctl_nxt[i+1] = c_ctl_r[i];
      if (ccw) begin
        c_x_nxt[i+1] = c_x_r[i] - ys;
        c_y_nxt[i+1] = c_y_r[i] + xs;
        c_z_nxt[i+1] = c_z_r[i] - at;
      end else begin
        c_x_nxt[i+1] = c_x_r[i] + ys;
        c_y_nxt[i+1] = c_y_r[i] - xs;
        c_z_nxt[i+1] = c_z_r[i] + at;
      end
    end
  end

  // ---------------- gain multiply stage ----------------
  cpc_pkg::cpc_ctl_t    p_ctl_r;
  logic signed [PW-1:0] p_prod_nxt, p_prod_r;
  logic signed [IW-1:0] p_y_r;
  logic signed [ZW-1:0] p_z_r;

  always_comb begin
    if (c_ctl_r[N].mode == cpc_pkg::MODE_C2P) begin
      p_prod_nxt = PW'(c_x_r[N]) * PW'(cpc_pkg::KGAIN);
    end else begin
      p_prod_nxt = PW'(c_x_r[N]);
    end
  end

  // ---------------- output stage ----------------
  logic signed [PW-1:0] ra_w, rb_w;
  logic signed [ZW-1:0] zr;
  logic [OW-1:0]        ra_o, rb_o;
  logic [OUT_TDW-1:0]   out_tdata_nxt, out_tdata_r;
  logic [1:0]           out_tuser_r;

  always_comb begin
    zr   = (p_z_r + Z_RND) >>> 10;
    ra_w = '0;
    rb_w = '0;
    if (p_ctl_r.mode == cpc_pkg::MODE_C2P) begin
      ra_w = (p_prod_r + RND_C2P) >>> (cpc_pkg::GUARD + 16);
      if (ra_w < 0) begin
        ra_w = '0;
      end else if (ra_w > MAXV_P) begin
        ra_w = MAXV_P;
      end
      if (zr > ZCLAMP) begin
        zr = ZCLAMP;
      end else if (zr < -ZCLAMP) begin
        zr = -ZCLAMP;
      end
      rb_w = PW'(zr);
    end else begin
      ra_w = (p_prod_r + RND_P2C) >>> 16;
      rb_w = (PW'(p_y_r) + RND_P2C) >>> 16;
      if (p_ctl_r.flip) begin
        ra_w = -ra_w;
        rb_w = -rb_w;
      end
      if (ra_w > MAXV_P) begin
        ra_w = MAXV_P;
      end else if (ra_w < -MAXV_P) begin
        ra_w = -MAXV_P;
      end
      if (rb_w > MAXV_P) begin
        rb_w = MAXV_P;
      end else if (rb_w < -MAXV_P) begin
        rb_w = -MAXV_P;
      end
    end
    ra_o = OW'(ra_w);
    rb_o = OW'(rb_w);
    if (p_ctl_r.status != cpc_pkg::STAT_OK) begin
      ra_o = '0;
      rb_o = '0;
    end
    out_tdata_nxt = OUT_TDW'({rb_o, ra_o});
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r     <= '0;
      p_ctl_r      <= '0;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k <= N; k++) begin
        c_ctl_r[k] <= '0;
      end
    end else if (adv) begin
      s1_ctl_r     <= s1_ctl_nxt;
      p_ctl_r      <= c_ctl_r[N];
      out_tvalid_r <= p_ctl_r.valid;
      for (int k = 0; k <= N; k++) begin
        c_ctl_r[k] <= c_ctl_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r      <= s1_x_nxt;
      s1_y_r      <= s1_y_nxt;
      s1_z_r      <= s1_z_nxt;
      s1_v_r      <= s1_v_nxt;
      s1_blo_r    <= s1_blo_nxt;
      for (int k = 0; k <= N; k++) begin
        c_x_r[k] <= c_x_nxt[k];
        c_y_r[k] <= c_y_nxt[k];
        c_z_r[k] <= c_z_nxt[k];
      end
      p_prod_r    <= p_prod_nxt;
      p_y_r       <= c_y_r[N];
      p_z_r       <= c_z_r[N];
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= p_ctl_r.status;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

FILE: hdl/cpc_checker.sv
module cpc_checker #(
  parameter int DATA_WIDTH = cpc_pkg::DATA_WIDTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [((2*DATA_WIDTH+2+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                          out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // input side stalls exactly when the output register is full and not taken
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow output register state");

  // pole or negative modulus gives zero results
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != cpc_pkg::STAT_OK |-> out_tdata[2*DATA_WIDTH+1:0] == '0)
    else $error("flagged result carries nonzero values");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == cpc_pkg::STAT_OK || out_tuser == cpc_pkg::STAT_POLE ||
                   out_tuser == cpc_pkg::STAT_NEG)
    else $error("unknown status code");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind cartesian_polar_converter_top cpc_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cpc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: tb/sv/tb.sv
module tb;

  localparam int DW       = cpc_pkg::DATA_WIDTH_DEF;
  localparam int RW       = DW + 1;
  localparam int NSTAGES  = (cpc_pkg::CORDIC_STAGES_DEF > cpc_pkg::ATAN_ENTRIES) ?
                            cpc_pkg::ATAN_ENTRIES : cpc_pkg::CORDIC_STAGES_DEF;
  localparam int IN_TW    = ((2*DW+7)/8)*8;
  localparam int OUT_TW   = ((2*DW+2+7)/8)*8;
  localparam int LATENCY  = cpc_pkg::CORDIC_STAGES_DEF + 3;
  localparam int LIMIT    = 400000;
  localparam int N_RANDOM = 900;
  localparam int HOLD_LEN = 300;

  typedef struct packed {
    logic             mode;
    logic [DW-1:0]    coord_a;
    logic [DW-1:0]    coord_b;
    logic [RW-1:0]    res_a;
    logic [RW-1:0]    res_b;
    logic [1:0]       status;
  } conversion_t;

  class conversion_checker;
    conversion_t pending_results[$];
    int errors;
    int n_c2p;
    int n_p2c;
    int n_special;

    function new();
      errors = 0;
      n_c2p = 0;
      n_p2c = 0;
      n_special = 0;
    endfunction

    task report(string msg);
      $display("[%0t] ERROR %s", $time, msg);
      errors++;
    endtask

    // fixed-point CORDIC in both directions, results at the output widths
    function conversion_t convert(logic m, logic [DW-1:0] a_in, logic [DW-1:0] b_in);
      longint a, b, x, y, z, xs, ys, ang, ra, rb, maxv, kg;
      longint d90, d180, d360;
      logic flip;
      logic [1:0] st;
      conversion_t r;
      a = longint'($signed(a_in));
      b = longint'($signed(b_in));
      kg = longint'(cpc_pkg::KGAIN);
      d90 = longint'(cpc_pkg::DEG90_Q6);
      d180 = longint'(cpc_pkg::DEG180_Q6);
      d360 = longint'(cpc_pkg::DEG360_Q6);
      maxv = (longint'(1) << DW) - 1;
      ra = 0;
      rb = 0;
      st = cpc_pkg::STAT_OK;
      flip = 1'b0;
      if (m == cpc_pkg::MODE_C2P) begin
        if (a == 0 && b == 0) begin
          st = cpc_pkg::STAT_POLE;
        end else begin
          x = a * (longint'(1) << cpc_pkg::GUARD);
          y = b * (longint'(1) << cpc_pkg::GUARD);
          z = 0;
          // left half plane: rotate by 180 first
          if (x < 0) begin
            z = (y >= 0) ? (d180 <<< 10) : -(d180 <<< 10);
            x = -x;
            y = -y;
          end
          for (int i = 0; i < NSTAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y < 0) begin
              x = x - ys;
              y = y + xs;
              z = z - longint'(cpc_pkg::ATAN_DEG16[i]);
            end else begin
              x = x + ys;
              y = y - xs;
              z = z + longint'(cpc_pkg::ATAN_DEG16[i]);
            end
          end
          ra = (x * kg + (longint'(1) << (cpc_pkg::GUARD + 15))) >>> (cpc_pkg::GUARD + 16);
          if (ra < 0) ra = 0;
          if (ra > maxv) ra = maxv;
          rb = (z + 512) >>> 10;
          if (rb < -d180) rb = -d180;
          if (rb > d180) rb = d180;
        end
      end else begin
        if (a == 0) begin
          st = cpc_pkg::STAT_POLE;
        end else if (a < 0) begin
          st = cpc_pkg::STAT_NEG;
        end else begin
          ang = b % d360;
          if (ang >= d180) ang -= d360;
          if (ang < -d180) ang += d360;
          if (ang > d90) begin
            ang -= d180;
            flip = 1'b1;
          end else if (ang < -d90) begin
            ang += d180;
            flip = 1'b1;
          end
          z = ang * 1024;
          x = a * kg;
          y = 0;
          for (int i = 0; i < NSTAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z < 0) begin
              x = x + ys;
              y = y - xs;
              z = z + longint'(cpc_pkg::ATAN_DEG16[i]);
            end else begin
              x = x - ys;
              y = y + xs;
              z = z - longint'(cpc_pkg::ATAN_DEG16[i]);
            end
          end
          ra = (x + 32768) >>> 16;
          rb = (y + 32768) >>> 16;
          if (flip) begin
            ra = -ra;
            rb = -rb;
          end
          if (ra < -maxv) ra = -maxv;
          if (ra > maxv) ra = maxv;
          if (rb < -maxv) rb = -maxv;
          if (rb > maxv) rb = maxv;
        end
      end
      r.mode = m;
      r.coord_a = a_in;
      r.coord_b = b_in;
      r.res_a = ra[RW-1:0];
      r.res_b = rb[RW-1:0];
      r.status = st;
      return r;
    endfunction

    function void note_point(logic m, logic [DW-1:0] a, logic [DW-1:0] b);
      conversion_t r;
      r = convert(m, a, b);
      if (m == cpc_pkg::MODE_C2P) n_c2p++;
      else n_p2c++;
      if (r.status != cpc_pkg::STAT_OK) n_special++;
      pending_results.push_back(r);
    endfunction

    task check_result(logic [RW-1:0] got_a, logic [RW-1:0] got_b, logic [1:0] got_st);
      conversion_t w;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: a=%0d b=%0d status=%0d",
                         $signed(got_a), $signed(got_b), got_st));
      end else begin
        w = pending_results.pop_front();
        if (got_a !== w.res_a)
          report($sformatf("mode %0d in (%0d,%0d): result_a %0d, want %0d", w.mode,
                           $signed(w.coord_a), $signed(w.coord_b), $signed(got_a),
                           $signed(w.res_a)));
        if (got_b !== w.res_b)
          report($sformatf("mode %0d in (%0d,%0d): result_b %0d, want %0d", w.mode,
                           $signed(w.coord_a), $signed(w.coord_b), $signed(got_b),
                           $signed(w.res_b)));
        if (got_st !== w.status)
          report($sformatf("mode %0d in (%0d,%0d): status %0d, want %0d", w.mode,
                           $signed(w.coord_a), $signed(w.coord_b), got_st, w.status));
      end
    endtask
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_TW-1:0] out_tdata;
  logic [1:0]        out_tuser;

  conversion_checker sb = new();

  bit steady;     // both sides run without idling
  bit hold_req;   // ask the receiver for a long hold-off
  int hold_count;
  int drain_count;
  int cycle_count;

  cartesian_polar_converter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_point(in_tuser, in_tdata[DW-1:0], in_tdata[2*DW-1:DW]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[RW-1:0], out_tdata[2*RW-1:RW], out_tuser);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count,
             sb.pending_results.size());
    $display("cartesian_polar_converter_top: mismatch");
    $finish;
  end

  // receiver: random ready pattern, plus long hold-offs on request
  initial begin
    int run_left;
    int hold_left;
    bit run_ready;
    run_left = 0;
    hold_left = 0;
    run_ready = 1'b1;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_LEN;
        hold_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          run_ready = ($urandom_range(0, 3) != 0);
          if (run_ready) run_left = $urandom_range(1, 20);
          else if ($urandom_range(0, 9) == 0) run_left = $urandom_range(15, 50);
          else run_left = $urandom_range(1, 3);
        end
        run_left--;
        out_tready <= run_ready;
      end
    end
  end

  task automatic send_point(logic m, logic [DW-1:0] a, logic [DW-1:0] b);
    in_tvalid <= 1'b1;
    in_tuser  <= m;
    in_tdata  <= IN_TW'({b, a});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // idle the input for a random stretch, mostly short
  task automatic sender_gap();
    int g;
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) g = 0;
    else if (r < 9) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // checked away from the rising edge so the monitor has logged the last transfer
  task automatic wait_drained();
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int sent;
    int len;
    int kind;
    bit no_gap;
    logic m;
    logic [DW-1:0] a;
    logic [DW-1:0] b;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    steady     = 1'b0;
    hold_req   = 1'b0;
    hold_count = 0;
    drain_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: poles, negative modulus, corners, half-plane and wrap cases
    send_point(cpc_pkg::MODE_C2P, 16'h0000, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h7FFF, 16'h7FFF);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h8000, 16'h8000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h8000, 16'h7FFF);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h7FFF, 16'h8000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'hFFFF, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'hFF00, 16'hFFFF);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h0000, 16'h8000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h0000, 16'h7FFF);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h8000, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_C2P, 16'h0001, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0000, 16'd100);   sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'hFFFF, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h8000, 16'd5760);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h7FFF, 16'h0000);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h7FFF, 16'h7FFF);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, 16'h8000);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, 16'd11520); sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, -16'sd11520); sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, 16'd5760);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, 16'd5761);  sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h0100, -16'sd5761); sender_gap();
    send_point(cpc_pkg::MODE_P2C, 16'h7FFF, -16'sd17280);
    in_tvalid <= 1'b0;
    wait_drained();

    // random phases
    sent = 0;
    for (int seg = 0; sent < N_RANDOM; seg++) begin
      steady = (seg % 7 == 3);
      no_gap = steady || seg == 2 || seg == 11;
      if (seg == 2 || seg == 11) hold_req = 1'b1;
      len = $urandom_range(20, 60);
      for (int k = 0; k < len; k++) begin
        m = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
          a = 16'($urandom);
          b = 16'($urandom);
        end else if (kind < 75) begin
          a = 16'($urandom_range(0, 1024) - 512);
          b = (m == cpc_pkg::MODE_P2C) ? 16'($urandom) :
              16'($urandom_range(0, 1024) - 512);
        end else if (kind < 85) begin
          // angles near multiples of 90 degrees
          a = 16'($urandom_range(1, 32767));
          b = 16'(5760 * ($urandom_range(0, 10) - 5) + $urandom_range(0, 6) - 3);
        end else if (kind < 92) begin
          a = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom);
          b = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'($urandom);
        end else begin
          a = ($urandom_range(0, 2) == 0) ? 16'h7FFF :
              (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h0001);
          b = ($urandom_range(0, 2) == 0) ? 16'h7FFF :
              (($urandom_range(0, 1) != 0) ? 16'h8000 : 16'hFFFF);
        end
        send_point(m, a, b);
        sent++;
        if (!no_gap) sender_gap();
      end
      steady = 1'b0;
      if (seg % 5 == 4) begin
        in_tvalid <= 1'b0;
        wait_drained();
        drain_count++;
      end
    end
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (LATENCY + 20) @(posedge clk);

    $display("converted %0d points: %0d Cartesian to polar, %0d polar to Cartesian",
             sb.n_c2p + sb.n_p2c, sb.n_c2p, sb.n_p2c);
    $display("%0d at pole or negative; output held off %0d times for %0d cycles; %0d full drains",
             sb.n_special, hold_count, HOLD_LEN, drain_count);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("cartesian_polar_converter_top: match");
    end else begin
      $display("%0d errors, %0d results pending", sb.errors, sb.pending_results.size());
      $display("cartesian_polar_converter_top: mismatch");
    end
    $finish;
  end

endmodule
